FILE: hw/rtl/dle_pkg.sv
package dle_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_INSERT_AT  = 3'd4,
        REQ_READ_AT    = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    // list offset used for the write port
    typedef enum logic [1:0] {
        WR_FIRST_M1 = 2'd0,
        WR_COUNT    = 2'd1,
        WR_IDX      = 2'd2,
        WR_POS      = 2'd3
    } wr_sel_t;

    // list offset used for the read port
    typedef enum logic [2:0] {
        RD_POS    = 3'd0,
        RD_ONE    = 3'd1,
        RD_BACK2  = 3'd2,
        RD_LAST   = 3'd3,
        RD_IDX_M2 = 3'd4
    } rd_sel_t;

    typedef enum logic [1:0] {
        VS_KEEP = 2'd0,
        VS_VAL  = 2'd1,
        VS_MEM  = 2'd2
    } vsrc_t;

    typedef enum logic [1:0] {
        RS_KEEP = 2'd0,
        RS_ZERO = 2'd1,
        RS_MEM  = 2'd2
    } rsrc_t;

    typedef struct packed {
        logic    load_req;
        logic    mem_wr;
        wr_sel_t wr_sel;
        logic    mem_rd;
        rd_sel_t rd_sel;
        logic    first_dec;
        logic    first_inc;
        logic    count_inc;
        logic    count_dec;
        vsrc_t   front_src;
        vsrc_t   back_src;
        rsrc_t   rd_src;
        logic    idx_load;
        logic    idx_dec;
        logic    stat_load;
        status_t stat;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        req_t req;
        logic empty;
        logic full;
        logic pos_gt_cnt;
        logic pos_ge_cnt;
        logic pos_zero;
        logic pos_eq_cnt;
        logic shift_last;
    } sts_t;

endpackage

FILE: hw/rtl/double_ended_list_engine_top.sv
// Steps, request accepted to result valid: pushes, end inserts, rejected requests
// and unused codes pass EXEC then DONE; pops and read at pass EXEC, LOAD, DONE.
// Middle insert: EXEC, then SHIFT once per moved word, one shifted word per cycle
// through the single write / single read port of the entry memory, then INS, DONE.
// Throughput: a new request is taken in the cycle the result is registered.
// Reset empties the list at once; the entry memory itself is not cleared.
module double_ended_list_engine_top
    import dle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  read_value,
    output logic [VALUE_W-1:0]  front_value,
    output logic [VALUE_W-1:0]  back_value,
    output logic [LEN_W-1:0]    length,
    output logic                is_empty
);

    cmd_t cmd;
    sts_t sts;

    dle_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dle_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .status      (status),
        .read_value  (read_value),
        .front_value (front_value),
        .back_value  (back_value),
        .length      (length),
        .is_empty    (is_empty)
    );

endmodule

FILE: hw/rtl/dle_ctrl.sv
module dle_ctrl
    import dle_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_LOAD  = 6'b000100,
        S_SHIFT = 6'b001000,
        S_INS   = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    function automatic cmd_t push_front_cmd(input cmd_t c, input logic empty);
        cmd_t r;
        r           = c;
        r.mem_wr    = 1'b1;
        r.wr_sel    = WR_FIRST_M1;
        r.first_dec = 1'b1;
        r.count_inc = 1'b1;
        r.front_src = VS_VAL;
        r.back_src  = empty ? VS_VAL : VS_KEEP;
        return r;
    endfunction

    function automatic cmd_t push_back_cmd(input cmd_t c, input logic empty);
        cmd_t r;
        r           = c;
        r.mem_wr    = 1'b1;
        r.wr_sel    = WR_COUNT;
        r.count_inc = 1'b1;
        r.back_src  = VS_VAL;
        r.front_src = empty ? VS_VAL : VS_KEEP;
        return r;
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end

            S_EXEC:
            begin
                cmd.stat_load = 1'b1;
                cmd.stat      = ST_OK;
                cmd.rd_src    = RS_ZERO;
                state_next    = S_DONE;
                case (sts.req)
                    REQ_PUSH_FRONT:
                    begin
                        if (sts.full)
                            cmd.stat = ST_FULL;
                        else
                            cmd = push_front_cmd(cmd, sts.empty);
                    end
                    REQ_PUSH_BACK:
                    begin
                        if (sts.full)
                            cmd.stat = ST_FULL;
                        else
                            cmd = push_back_cmd(cmd, sts.empty);
                    end
                    REQ_POP_FRONT:
                    begin
                        if (sts.empty)
                            cmd.stat = ST_EMPTY;
                        else
                        begin
                            cmd.mem_rd    = 1'b1;
                            cmd.rd_sel    = RD_ONE;
                            cmd.first_inc = 1'b1;
                            cmd.count_dec = 1'b1;
                            state_next    = S_LOAD;
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (sts.empty)
                            cmd.stat = ST_EMPTY;
                        else
                        begin
                            cmd.mem_rd    = 1'b1;
                            cmd.rd_sel    = RD_BACK2;
                            cmd.count_dec = 1'b1;
                            state_next    = S_LOAD;
                        end
                    end
                    REQ_INSERT_AT:
                    begin
                        priority if (sts.pos_gt_cnt)
                            cmd.stat = ST_RANGE;
                        else if (sts.full)
                            cmd.stat = ST_FULL;
                        else if (sts.pos_zero)
                            cmd = push_front_cmd(cmd, sts.empty);
                        else if (sts.pos_eq_cnt)
                            cmd = push_back_cmd(cmd, sts.empty);
                        else
                        begin
                            // middle insert: move the tail one step back first
                            cmd.mem_rd   = 1'b1;
                            cmd.rd_sel   = RD_LAST;
                            cmd.idx_load = 1'b1;
                            state_next   = S_SHIFT;
                        end
                    end
                    REQ_READ_AT:
                    begin
                        if (sts.pos_ge_cnt)
                            cmd.stat = ST_RANGE;
                        else
                        begin
                            cmd.mem_rd = 1'b1;
                            cmd.rd_sel = RD_POS;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_LOAD:
            begin
                case (sts.req)
                    REQ_POP_FRONT: cmd.front_src = VS_MEM;
                    REQ_POP_BACK:  cmd.back_src  = VS_MEM;
                    REQ_READ_AT:   cmd.rd_src    = RS_MEM;
                    default:
                    begin
                    end
                endcase
                state_next = S_DONE;
            end

            S_SHIFT:
            begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_sel  = WR_IDX;
                cmd.mem_rd  = 1'b1;
                cmd.rd_sel  = RD_IDX_M2;
                cmd.idx_dec = 1'b1;
                if (sts.shift_last)
                    state_next = S_INS;
            end

            S_INS:
            begin
                cmd.mem_wr    = 1'b1;
                cmd.wr_sel    = WR_POS;
                cmd.count_inc = 1'b1;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    in_ready     = 1'b1;
                    if (in_valid)
                    begin
                        cmd.load_req = 1'b1;
                        state_next   = S_EXEC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/dle_datapath.sv
module dle_datapath
    import dle_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output sts_t                sts,
    input  logic [REQ_W-1:0]    req_type,
    input  logic [VALUE_W-1:0]  value,
    input  logic [POS_W-1:0]    position,
    output logic [STATUS_W-1:0] status,
    output logic [VALUE_W-1:0]  read_value,
    output logic [VALUE_W-1:0]  front_value,
    output logic [VALUE_W-1:0]  back_value,
    output logic [LEN_W-1:0]    length,
    output logic                is_empty
);

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rdata_reg;

    logic [SW-1:0]         first_reg, first_next;
    logic [CW-1:0]         count_reg, count_next;
    req_t                  req_reg, req_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic [DATA_WIDTH-1:0] rd_reg, rd_next;
    status_t               stat_reg, stat_next;
    logic [CW-1:0]         idx_reg, idx_next;

    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [VALUE_W-1:0]    out_read_reg, out_read_next;
    logic [VALUE_W-1:0]    out_front_reg, out_front_next;
    logic [VALUE_W-1:0]    out_back_reg, out_back_next;
    logic [LEN_W-1:0]      out_len_reg, out_len_next;
    logic                  out_empty_reg, out_empty_next;

    logic [PW-1:0]         cnt_ext, pos_ext, idx_ext;
    logic [CW-1:0]         pos_k, back2_k, rd_k, wr_k;
    logic [SW-1:0]         rd_addr, wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [63:0]           value_wide, front_wide, back_wide, rd_wide;
    logic                  cnt_zero;

    // circular slot of list offset k: one add and one conditional subtract
    function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {{(CW + 1 - SW){1'b0}}, base} + {1'b0, k};
        if (s >= (CW + 1)'(CAPACITY))
            s = s - (CW + 1)'(CAPACITY);
        return s[SW-1:0];
    endfunction

    assign cnt_ext  = PW'(count_reg);
    assign pos_ext  = PW'(pos_reg);
    assign idx_ext  = PW'(idx_reg);
    assign cnt_zero = (count_reg == '0);

    assign sts.req        = req_reg;
    assign sts.empty      = cnt_zero;
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.pos_gt_cnt = (pos_ext > cnt_ext);
    assign sts.pos_ge_cnt = (pos_ext >= cnt_ext);
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.pos_eq_cnt = (pos_ext == cnt_ext);
    assign sts.shift_last = (idx_ext == pos_ext + PW'(1));

    assign pos_k   = pos_ext[CW-1:0];
    assign back2_k = (count_reg >= CW'(2)) ? count_reg - CW'(2) : '0;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_POS:    rd_k = pos_k;
            RD_ONE:    rd_k = CW'(1);
            RD_BACK2:  rd_k = back2_k;
            RD_LAST:   rd_k = count_reg - CW'(1);
            RD_IDX_M2: rd_k = idx_reg - CW'(2);
            default:   rd_k = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            WR_FIRST_M1: wr_k = CW'(CAPACITY - 1);
            WR_COUNT:    wr_k = count_reg;
            WR_IDX:      wr_k = idx_reg;
            WR_POS:      wr_k = pos_k;
        endcase
    end

    assign rd_addr = slot_of(first_reg, rd_k);
    assign wr_addr = slot_of(first_reg, wr_k);
    assign wr_data = (cmd.wr_sel == WR_IDX) ? rdata_reg : val_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_wr)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_rd)
            rdata_reg <= mem[rd_addr];
    end

    assign value_wide = {32'b0, value};

    always_comb
    begin
        req_next = req_reg;
        val_next = val_reg;
        pos_next = pos_reg;
        if (cmd.load_req)
        begin
            req_next = req_t'(req_type);
            val_next = value_wide[DATA_WIDTH-1:0];
            pos_next = position;
        end

        first_next = first_reg;
        if (cmd.first_dec)
            first_next = (first_reg == '0) ? SW'(CAPACITY - 1) : first_reg - SW'(1);
        else if (cmd.first_inc)
            first_next = (first_reg == SW'(CAPACITY - 1)) ? '0 : first_reg + SW'(1);

        count_next = count_reg;
        if (cmd.count_inc)
            count_next = count_reg + CW'(1);
        else if (cmd.count_dec)
            count_next = count_reg - CW'(1);

        idx_next = idx_reg;
        if (cmd.idx_load)
            idx_next = count_reg;
        else if (cmd.idx_dec)
            idx_next = idx_reg - CW'(1);

        case (cmd.front_src)
            VS_VAL:  front_next = val_reg;
            VS_MEM:  front_next = rdata_reg;
            default: front_next = front_reg;
        endcase

        case (cmd.back_src)
            VS_VAL:  back_next = val_reg;
            VS_MEM:  back_next = rdata_reg;
            default: back_next = back_reg;
        endcase

        case (cmd.rd_src)
            RS_ZERO: rd_next = '0;
            RS_MEM:  rd_next = rdata_reg;
            default: rd_next = rd_reg;
        endcase

        stat_next = cmd.stat_load ? cmd.stat : stat_reg;
    end

    assign front_wide = 64'(front_reg);
    assign back_wide  = 64'(back_reg);
    assign rd_wide    = 64'(rd_reg);

    always_comb
    begin
        out_status_next = out_status_reg;
        out_read_next   = out_read_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_len_next    = out_len_reg;
        out_empty_next  = out_empty_reg;
        if (cmd.out_load)
        begin
            out_status_next = stat_reg;
            out_read_next   = rd_wide[VALUE_W-1:0];
            out_front_next  = cnt_zero ? '0 : front_wide[VALUE_W-1:0];
            out_back_next   = cnt_zero ? '0 : back_wide[VALUE_W-1:0];
            out_len_next    = cnt_ext[LEN_W-1:0];
            out_empty_next  = cnt_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            first_reg <= first_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        val_reg        <= val_next;
        pos_reg        <= pos_next;
        front_reg      <= front_next;
        back_reg       <= back_next;
        rd_reg         <= rd_next;
        stat_reg       <= stat_next;
        idx_reg        <= idx_next;
        out_status_reg <= out_status_next;
        out_read_reg   <= out_read_next;
        out_front_reg  <= out_front_next;
        out_back_reg   <= out_back_next;
        out_len_reg    <= out_len_next;
        out_empty_reg  <= out_empty_next;
    end

    assign status      = out_status_reg;
    assign read_value  = out_read_reg;
    assign front_value = out_front_reg;
    assign back_value  = out_back_reg;
    assign length      = out_len_reg;
    assign is_empty    = out_empty_reg;

endmodule

FILE: sim/tb_double_ended_list_engine_top.sv
module tb_double_ended_list_engine_top;
    import dle_pkg::*;

    localparam int LIST_DEPTH = CAPACITY_DEF;

    // request codes with no operation behind them
    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    typedef struct packed {
        status_t            st;
        logic [VALUE_W-1:0] rd;
        logic [VALUE_W-1:0] fr;
        logic [VALUE_W-1:0] bk;
        logic [LEN_W-1:0]   len;
        logic               emp;
    } list_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]   rq;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        logic               typed;
        list_result_t       want;
    } dir_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type = '0;
    logic [VALUE_W-1:0]  value = '0;
    logic [POS_W-1:0]    position = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_value;
    logic [VALUE_W-1:0]  front_value;
    logic [VALUE_W-1:0]  back_value;
    logic [LEN_W-1:0]    length;
    logic                is_empty;

    // typed expectation travels with the request it belongs to
    logic                item_typed = 1'b0;
    list_result_t        item_want = '0;

    // shadow copy of the list
    logic [VALUE_W-1:0]  list_mem [LIST_DEPTH];
    int                  head_slot;
    int                  list_len;

    list_result_t        pending_results [$];
    list_result_t        next_result;
    list_result_t        seen_result;
    list_result_t        oldest_result;
    int                  bad_count;
    int                  send_idle;
    int                  recv_idle;
    logic                hold_rx = 1'b0;
    int                  walk_mode;
    int                  mode_left;
    dir_row_t            dir_tab [$];

    double_ended_list_engine_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .front_value (front_value),
        .back_value  (back_value),
        .length      (length),
        .is_empty    (is_empty)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int slot_at(int k);
        return (head_slot + k) % LIST_DEPTH;
    endfunction

    function automatic status_t put_front(logic [VALUE_W-1:0] v);
        if (list_len >= LIST_DEPTH)
            return ST_FULL;
        head_slot = (head_slot + LIST_DEPTH - 1) % LIST_DEPTH;
        list_mem[head_slot] = v;
        list_len++;
        return ST_OK;
    endfunction

    function automatic status_t put_back(logic [VALUE_W-1:0] v);
        if (list_len >= LIST_DEPTH)
            return ST_FULL;
        list_mem[slot_at(list_len)] = v;
        list_len++;
        return ST_OK;
    endfunction

    // applies one request to the shadow list and returns the result it gives
    function automatic list_result_t apply_list_req(logic [REQ_W-1:0] rq,
                                                    logic [VALUE_W-1:0] v,
                                                    logic [POS_W-1:0] p);
        list_result_t r;
        int           k;
        int           pi;
        r = '0;
        r.st = ST_OK;
        pi = int'(p);
        case (rq)
            REQ_PUSH_FRONT: r.st = put_front(v);
            REQ_PUSH_BACK:  r.st = put_back(v);
            REQ_POP_FRONT:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    head_slot = slot_at(1);
                    list_len--;
                end
            end
            REQ_POP_BACK:
            begin
                if (list_len == 0)
                    r.st = ST_EMPTY;
                else
                    list_len--;
            end
            REQ_INSERT_AT:
            begin
                if (pi > list_len)
                    r.st = ST_RANGE;
                else if (list_len >= LIST_DEPTH)
                    r.st = ST_FULL;
                else if (pi == 0)
                    r.st = put_front(v);
                else if (pi == list_len)
                    r.st = put_back(v);
                else
                begin
                    for (k = list_len; k > pi; k--)
                        list_mem[slot_at(k)] = list_mem[slot_at(k - 1)];
                    list_mem[slot_at(pi)] = v;
                    list_len++;
                end
            end
            REQ_READ_AT:
            begin
                if (pi >= list_len)
                    r.st = ST_RANGE;
                else
                    r.rd = list_mem[slot_at(pi)];
            end
            default: ;
        endcase
        if (list_len != 0)
        begin
            r.fr = list_mem[slot_at(0)];
            r.bk = list_mem[slot_at(list_len - 1)];
        end
        r.len = list_len[LEN_W-1:0];
        r.emp = (list_len == 0);
        return r;
    endfunction

    // predictor and scoreboard, both on the pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                next_result = apply_list_req(req_type, value, position);
                if (item_typed)
                    next_result = item_want;
                pending_results.push_back(next_result);
            end
            if (out_valid && out_ready)
            begin
                seen_result.st  = status_t'(status);
                seen_result.rd  = read_value;
                seen_result.fr  = front_value;
                seen_result.bk  = back_value;
                seen_result.len = length;
                seen_result.emp = is_empty;
                if (pending_results.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result st=%0d rd=%h fr=%h bk=%h len=%0d emp=%0b",
                                 seen_result.st, seen_result.rd, seen_result.fr,
                                 seen_result.bk, seen_result.len, seen_result.emp);
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (seen_result !== oldest_result)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("mismatch exp st=%0d rd=%h fr=%h bk=%h len=%0d emp=%0b",
                                     oldest_result.st, oldest_result.rd, oldest_result.fr,
                                     oldest_result.bk, oldest_result.len, oldest_result.emp);
                            $display("         got st=%0d rd=%h fr=%h bk=%h len=%0d emp=%0b",
                                     seen_result.st, seen_result.rd, seen_result.fr,
                                     seen_result.bk, seen_result.len, seen_result.emp);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
        out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle);

    task automatic send_req(logic [REQ_W-1:0] rq, logic [VALUE_W-1:0] v,
                            logic [POS_W-1:0] p, logic typed, list_result_t want);
        if ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rq;
        value      <= v;
        position   <= p;
        item_typed <= typed;
        item_want  <= want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 16) @(posedge clk);
    endtask

    function automatic dir_row_t dir_entry(logic [REQ_W-1:0] rq, logic [VALUE_W-1:0] v,
                                           logic [POS_W-1:0] p, logic typed,
                                           status_t st, logic [VALUE_W-1:0] rd,
                                           logic [VALUE_W-1:0] fr, logic [VALUE_W-1:0] bk,
                                           int len, logic emp);
        dir_row_t d;
        d.rq = rq;
        d.v = v;
        d.p = p;
        d.typed = typed;
        d.want.st = st;
        d.want.rd = rd;
        d.want.fr = fr;
        d.want.bk = bk;
        d.want.len = len[LEN_W-1:0];
        d.want.emp = emp;
        return d;
    endfunction

    // grow, shrink or wander; keeps the list moving between empty and full
    function automatic logic [REQ_W-1:0] pick_req(int mode);
        int r;
        r = $urandom_range(99);
        if (r < 2)
            return $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
        case (mode)
            0:
            begin
                if (r < 27) return REQ_PUSH_FRONT;
                if (r < 52) return REQ_PUSH_BACK;
                if (r < 82) return REQ_INSERT_AT;
                if (r < 92) return REQ_READ_AT;
                if (r < 96) return REQ_POP_FRONT;
                return REQ_POP_BACK;
            end
            1:
            begin
                if (r < 32) return REQ_POP_FRONT;
                if (r < 62) return REQ_POP_BACK;
                if (r < 77) return REQ_READ_AT;
                if (r < 85) return REQ_PUSH_FRONT;
                if (r < 93) return REQ_PUSH_BACK;
                return REQ_INSERT_AT;
            end
            default:
            begin
                if (r < 18) return REQ_PUSH_FRONT;
                if (r < 34) return REQ_PUSH_BACK;
                if (r < 50) return REQ_POP_FRONT;
                if (r < 66) return REQ_POP_BACK;
                if (r < 83) return REQ_INSERT_AT;
                return REQ_READ_AT;
            end
        endcase
    endfunction

    task automatic run_random(int n);
        int                 i;
        int                 r;
        int                 hint;
        logic [REQ_W-1:0]   rq;
        logic [VALUE_W-1:0] v;
        logic [POS_W-1:0]   p;
        for (i = 0; i < n; i++)
        begin
            if (mode_left == 0)
            begin
                walk_mode = $urandom_range(2);
                mode_left = $urandom_range(200, 60);
            end
            mode_left--;
            rq = pick_req(walk_mode);
            r = $urandom_range(9);
            if (r == 0)
                v = '0;
            else if (r == 1)
                v = '1;
            else
                v = $urandom;
            // count is only a hint here; the predictor holds the truth
            hint = list_len;
            r = $urandom_range(9);
            if (r < 7)
                p = (rq == REQ_READ_AT && hint > 0) ? POS_W'($urandom_range(hint - 1))
                                                    : POS_W'($urandom_range(hint));
            else if (r < 8)
                p = POS_W'(hint + $urandom_range(1));
            else
                p = POS_W'($urandom_range(127));
            send_req(rq, v, p, 1'b0, '0);
        end
    endtask

    initial
    begin
        #18000000;
        $display("double_ended_list_engine_top regression: fail");
        $finish;
    end

    initial
    begin
        int idx;
        int k;
        for (k = 0; k < LIST_DEPTH; k++)
            list_mem[k] = '0;
        head_slot = 0;
        list_len = 0;
        bad_count = 0;
        walk_mode = 0;
        mode_left = 0;
        send_idle = 19;
        recv_idle = 84;

        dir_tab.push_back(dir_entry(REQ_POP_FRONT, 32'h0, 7'd0, 1'b1,
                                    ST_EMPTY, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_POP_BACK, 32'h0, 7'd0, 1'b1,
                                    ST_EMPTY, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_READ_AT, 32'h0, 7'd0, 1'b1,
                                    ST_RANGE, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h5, 7'd1, 1'b1,
                                    ST_RANGE, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_SPARE_6, 32'h0, 7'd0, 1'b1,
                                    ST_OK, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_SPARE_7, 32'hFFFF_FFFF, 7'd127, 1'b1,
                                    ST_OK, 0, 0, 0, 0, 1'b1));
        dir_tab.push_back(dir_entry(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 7'd0, 1'b1,
                                    ST_OK, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0));
        dir_tab.push_back(dir_entry(REQ_PUSH_BACK, 32'h0, 7'd127, 1'b1,
                                    ST_OK, 0, 32'hFFFF_FFFF, 32'h0, 2, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h1234_5678, 7'd1, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_READ_AT, 32'h0, 7'd1, 1'b1,
                                    ST_OK, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 3, 1'b0));
        dir_tab.push_back(dir_entry(REQ_READ_AT, 32'h0, 7'd3, 1'b1,
                                    ST_RANGE, 0, 32'hFFFF_FFFF, 32'h0, 3, 1'b0));
        dir_tab.push_back(dir_entry(REQ_READ_AT, 32'hFFFF_FFFF, 7'd127, 1'b1,
                                    ST_RANGE, 0, 32'hFFFF_FFFF, 32'h0, 3, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'hA5A5_A5A5, 7'd3, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h1, 7'd0, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h9, 7'd6, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h5A5A_5A5A, 7'd2, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_READ_AT, 32'h0, 7'd4, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_POP_FRONT, 32'h0, 7'd0, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_POP_BACK, 32'h0, 7'd0, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_PUSH_BACK, 32'h8000_0000, 7'd0, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_INSERT_AT, 32'h7FFF_FFFF, 7'd127, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));
        dir_tab.push_back(dir_entry(REQ_PUSH_FRONT, 32'h0000_0001, 7'd64, 1'b0,
                                    ST_OK, 0, 0, 0, 0, 1'b0));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < dir_tab.size(); idx++)
            send_req(dir_tab[idx].rq, dir_tab[idx].v, dir_tab[idx].p,
                     dir_tab[idx].typed, dir_tab[idx].want);

        run_random(700);

        // sender goes quiet until every result is back
        drain_results();
        send_idle = 84;
        recv_idle = 19;
        run_random(700);

        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (400) @(posedge clk);
                hold_rx <= 1'b0;
            end
        join_none
        run_random(650);

        drain_results();
        if (bad_count == 0)
            $display("double_ended_list_engine_top regression: pass");
        else
            $display("double_ended_list_engine_top regression: fail");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dle_pkg.sv
hw/rtl/dle_ctrl.sv
hw/rtl/dle_datapath.sv
hw/rtl/double_ended_list_engine_top.sv
sim/tb_double_ended_list_engine_top.sv
